@@ rtl/rga_pkg.sv @@
// ----------------------------------------------------------------------------
// rga_pkg
// Shared widths, constants and controller/datapath command types for the
// random grant arbiter.
// ----------------------------------------------------------------------------
package rga_pkg;

   // payload field widths
   localparam int REQ_W  = 16;
   localparam int IDX_W  = 4;
   localparam int SEED_W = 48;

   // request action codes
   localparam logic ACT_ARBITRATE = 1'b0;
   localparam logic ACT_RESEED    = 1'b1;

   // 48-bit linear congruential generator
   localparam int                MUL_CHUNK_W = 12;
   localparam int                MUL_CHUNKS  = 3;
   localparam logic [MUL_CHUNKS*MUL_CHUNK_W-1:0] LCG_MUL = 36'h5_DEEC_E66D;
   localparam logic [SEED_W-1:0] LCG_ADD     = 48'hB;
   localparam logic [SEED_W-1:0] SEED_RESET  = {16'h7223, 16'hAB34, 16'hDE76};

   // random value is bits 47..17 of the new generator state
   localparam int RAND_LSB   = 17;
   localparam int RAND_W     = SEED_W - RAND_LSB;
   // dividend padded to a whole number of two-bit steps
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIVIDEND_W     = 32;
   localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;
   // request count 1..16 and remainder 0..15
   localparam int CNT_W = 5;
   localparam int REM_W = 4;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       decide;
      logic       reseed;
      logic       mul_step;
      logic [1:0] mul_sel;
      logic       commit;
      logic       div_step;
      logic       scan_step;
      logic       emit;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_reseed;
      logic arb_needed;
      logic found;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/rga_req_if.sv @@
// ----------------------------------------------------------------------------
// rga_req_if
// Request channel: one output's request vector or a reseed action.
// ----------------------------------------------------------------------------
interface rga_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [rga_pkg::IDX_W-1:0]   output_index;
   logic [rga_pkg::REQ_W-1:0]   request_mask;

   modport source (output valid, output action, output output_index,
                   output request_mask, input ready);
   modport sink   (input valid, input action, input output_index,
                   input request_mask, output ready);
endinterface

@@ rtl/rga_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rga_rsp_if
// Response channel: the grant decision for one request.
// ----------------------------------------------------------------------------
interface rga_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rga_pkg::IDX_W-1:0]   granted_output;
   logic                        grant_valid;
   logic [rga_pkg::IDX_W-1:0]   grant_input;

   modport source (output valid, output granted_output, output grant_valid,
                   output grant_input, input ready);
   modport sink   (input valid, input granted_output, input grant_valid,
                   input grant_input, output ready);
endinterface

@@ rtl/random_grant_arbiter.sv @@
// ----------------------------------------------------------------------------
// random_grant_arbiter
// Uniform random input selection for one crossbar output per request, driven
// by a 48-bit linear congruential generator with a reloadable seed.
// ----------------------------------------------------------------------------
// Each request carries one output's request vector; the block answers with
// exactly one response. With at least one valid request bit and an output
// index in range the generator advances once and the k-th set bit is
// granted, k being bits 47..17 of the new generator value modulo the
// request count. After acceptance a request steps through the 48x12 partial
// products of the generator multiply, a commit, the remainder at two bits a
// cycle and a bit-serial scan of the request bits up to the granted one
// before its response is loaded. Reseeds and requests with nothing to grant
// skip the multiply, remainder and scan. The response sits in an output
// register, so a new request is accepted while the previous response waits
// to be taken. The seed register may be written at any time; it only
// reaches the generator through a reseed request.
module random_grant_arbiter #(
   parameter int NUM_INPUTS  = 16,
   parameter int NUM_OUTPUTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   rga_req_if.sink                    req_chan,
   rga_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [rga_pkg::SEED_W-1:0] csr_wr_data
);

   rga_pkg::dp_cmd_type    dp_cmd;
   rga_pkg::dp_status_type dp_status;

   // sequencer
   rga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // datapath
   rga_dp #(
      .NUM_INPUTS  (NUM_INPUTS),
      .NUM_OUTPUTS (NUM_OUTPUTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_action         (req_chan.action),
      .req_output_index   (req_chan.output_index),
      .req_request_mask   (req_chan.request_mask),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_granted_output (rsp_chan.granted_output),
      .rsp_grant_valid    (rsp_chan.grant_valid),
      .rsp_grant_input    (rsp_chan.grant_input)
   );

endmodule

@@ rtl/rga_ctrl.sv @@
// ----------------------------------------------------------------------------
// rga_ctrl
// Sequencer for the arbiter: accepts a request, for an arbitration steps the generator multiply,
// the remainder and the request scan, then hands the result to the output.
// ----------------------------------------------------------------------------
module rga_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rga_pkg::dp_status_type status,
   output rga_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_SCAN   = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   localparam int STEP_W = $clog2(rga_pkg::DIV_STEPS);
   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(rga_pkg::MUL_CHUNKS - 1);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(rga_pkg::DIV_STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = step_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            step_in    = '0;
            if (status.is_reseed) begin
               cmd.reseed = 1'b1;
               state_in   = ST_EMIT;
            end else if (status.arb_needed) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (step_ff == MUL_LAST) begin
               state_in = ST_COMMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_SCAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.found) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ rtl/rga_dp.sv @@
// ----------------------------------------------------------------------------
// rga_dp
// Arbiter datapath: seed and generator registers, chunked LCG multiply,
// two-bit-per-step remainder, bit-serial request scan and output register.
// ----------------------------------------------------------------------------
module rga_dp #(
   parameter int NUM_INPUTS  = 16,
   parameter int NUM_OUTPUTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rga_pkg::dp_cmd_type           cmd,
   output rga_pkg::dp_status_type        status,
   input  logic                          req_action,
   input  logic [rga_pkg::IDX_W-1:0]     req_output_index,
   input  logic [rga_pkg::REQ_W-1:0]     req_request_mask,
   input  logic                          csr_wr_en,
   input  logic [rga_pkg::SEED_W-1:0]    csr_wr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [rga_pkg::IDX_W-1:0]     rsp_granted_output,
   output logic                          rsp_grant_valid,
   output logic [rga_pkg::IDX_W-1:0]     rsp_grant_input
);

   localparam int REQ_W  = rga_pkg::REQ_W;
   localparam int IDX_W  = rga_pkg::IDX_W;
   localparam int SEED_W = rga_pkg::SEED_W;
   localparam int CW     = rga_pkg::MUL_CHUNK_W;
   localparam int CNT_W  = rga_pkg::CNT_W;
   localparam int REM_W  = rga_pkg::REM_W;
   localparam int DVD_W  = rga_pkg::DIVIDEND_W;

   // request lines that exist in this configuration
   localparam logic [REQ_W-1:0] REQ_ENABLE = (NUM_INPUTS >= REQ_W) ? {REQ_W{1'b1}} :
                                              REQ_W'((64'd1 << NUM_INPUTS) - 64'd1);

   // generator and seed
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [SEED_W-1:0] gen_ff, gen_in;
   logic [SEED_W-1:0] acc_ff, acc_in;
   // captured request
   logic              act_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [REQ_W-1:0]  mask_ff, mask_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   // remainder and grant
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  grant_ff, grant_in;
   logic              gv_ff, gv_in;
   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  out_idx_ff;
   logic              out_gv_ff;
   logic [IDX_W-1:0]  out_grant_ff;

   logic [CW-1:0]        mul_chunk;
   logic [SEED_W+CW-1:0] mul_prod;
   logic [SEED_W-1:0]    mul_term;
   logic [CNT_W-1:0]     pop_cnt;
   logic                 out_ok;
   logic [REM_W:0]       div_t;
   logic [DVD_W-1:0]     div_d;

   // one 48x12 partial product per step
   assign mul_chunk = rga_pkg::LCG_MUL[32'(cmd.mul_sel) * CW +: CW];
   assign mul_prod  = gen_ff * mul_chunk;
   assign mul_term  = SEED_W'(mul_prod) << (32'(cmd.mul_sel) * CW);

   // request count
   always_comb begin
      pop_cnt = '0;
      for (int i = 0; i < REQ_W; i++) begin
         pop_cnt = pop_cnt + CNT_W'(mask_ff[i]);
      end
   end

   assign out_ok = (32'(idx_ff) < 32'(NUM_OUTPUTS));

   // two restoring remainder steps
   always_comb begin
      div_t = {1'b0, rem_ff};
      div_d = dvd_ff;
      for (int i = 0; i < rga_pkg::DIV_RADIX_BITS; i++) begin
         div_t = {div_t[REM_W-1:0], div_d[DVD_W-1]};
         div_d = {div_d[DVD_W-2:0], 1'b0};
         if (div_t >= cnt_ff) begin
            div_t = div_t - cnt_ff;
         end
      end
   end

   // status to controller
   always_comb begin
      status.is_reseed  = (act_ff == rga_pkg::ACT_RESEED);
      status.arb_needed = out_ok && (mask_ff != '0);
      status.found      = mask_ff[0] && (rem_ff == '0);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // next values
   always_comb begin
      seed_in      = seed_ff;
      gen_in       = gen_ff;
      acc_in       = acc_ff;
      mask_in      = mask_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      grant_in     = grant_ff;
      gv_in        = gv_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_wr_en) begin
         seed_in = csr_wr_data;
      end
      if (cmd.capture) begin
         mask_in = req_request_mask & REQ_ENABLE;
         pos_in  = '0;
         acc_in  = rga_pkg::LCG_ADD;
      end
      if (cmd.decide) begin
         cnt_in   = pop_cnt;
         grant_in = '0;
         gv_in    = 1'b0;
      end
      if (cmd.reseed) begin
         gen_in = seed_ff;
      end
      if (cmd.mul_step) begin
         acc_in = acc_ff + mul_term;
      end
      if (cmd.commit) begin
         gen_in = acc_ff;
         dvd_in = DVD_W'(acc_ff[SEED_W-1:rga_pkg::RAND_LSB]);
         rem_in = '0;
      end
      if (cmd.div_step) begin
         dvd_in = div_d;
         rem_in = div_t[REM_W-1:0];
      end
      // walk the request bits, counting the remainder down on each set bit
      if (cmd.scan_step) begin
         if (mask_ff[0]) begin
            if (rem_ff == '0) begin
               grant_in = pos_ff;
               gv_in    = 1'b1;
            end else begin
               rem_in = rem_ff - 1'b1;
            end
         end
         mask_in = mask_ff >> 1;
         pos_in  = pos_ff + 1'b1;
      end
      // output register handshake
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and generator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= rga_pkg::SEED_RESET;
         gen_ff       <= rga_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         idx_ff <= req_output_index;
      end
      acc_ff   <= acc_in;
      mask_ff  <= mask_in;
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      grant_ff <= grant_in;
      gv_ff    <= gv_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_idx_ff   <= idx_ff;
         out_gv_ff    <= gv_ff;
         out_grant_ff <= gv_ff ? grant_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_output = out_idx_ff;
   assign rsp_grant_valid    = out_gv_ff;
   assign rsp_grant_input    = out_grant_ff;

endmodule
